// ===== hw/rtl/deq_pkg.sv =====
`default_nettype none

package deq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int DATA_BITS_DEF = 32;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int READ_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - READ_W - COUNT_W - 1;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PEEK_REAR  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/deq_addr_unit.sv =====
`default_nettype none

module deq_addr_unit #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic [AW-1:0] head,
  input  wire logic [CW-1:0] idx,
  output logic      [AW-1:0] addr
);

  logic [CW:0] sum;
  logic [CW:0] wrapped;

  always_comb begin
    sum = (CW + 1)'(head) + (CW + 1)'(idx);
    if (sum >= (CW + 1)'(DEPTH)) begin
      wrapped = sum - (CW + 1)'(DEPTH);
    end else begin
      wrapped = sum;
    end
    addr = AW'(wrapped);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
// Bounded double-ended queue of DEPTH words kept in a circular buffer RAM.
// Each input transfer carries one operation (push/pop/peek at either end,
// or insert at a zero-based position from 1 to the count) and produces
// exactly one result transfer with the word read, a status, the count and
// an empty flag. The block takes one operation at a time, and a result held
// back by out_tready holds the block as well. The insert time comes from the
// single-port RAM: every word behind the insert point is read (S_SHRD) and
// written back (S_SHWR) one place toward the rear, one word after another,
// with one shared address adder mapping queue positions onto RAM addresses.
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH     = deq_pkg::DEPTH_DEF,
  parameter int DATA_BITS = deq_pkg::DATA_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [deq_pkg::IN_DATA_W-1:0] in_tdata,   // value[31:0], position[36:32]
  input  wire logic [deq_pkg::KIND_W-1:0]    in_tuser,   // kind[2:0]
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [deq_pkg::OUT_DATA_W-1:0]     out_tdata,  // read_value[31:0], entry_count[36:32],
                                                         // is_empty[37]
  output logic [deq_pkg::STATUS_W-1:0]       out_tuser   // status[1:0]
);

  import deq_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SW  = (DATA_BITS < VALUE_W) ? DATA_BITS : VALUE_W;
  localparam int PCW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDATA,
    S_SHRD,
    S_SHWR,
    S_INSW,
    S_RESULT
  } state_t;

  state_t              state_r, state_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [SW-1:0]       word_r, word_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       j_r, j_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [SW-1:0]       rd_r, rd_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [READ_W-1:0]   out_read_r, out_read_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                out_empty_r, out_empty_nxt;

  logic [SW-1:0] mem [DEPTH];
  logic [SW-1:0] rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [SW-1:0] mem_wdata;
  logic          mem_re;

  logic [CW-1:0] unit_idx;
  logic [AW-1:0] unit_addr;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] jm1;
  logic          is_full;
  logic          is_empty;
  logic          pos_ok;

  deq_addr_unit #(
    .DEPTH(DEPTH)
  ) u_addr (
    .head(head_r),
    .idx (unit_idx),
    .addr(unit_addr)
  );

  always_comb begin
    head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
    head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
    cnt_m1   = count_r - CW'(1);
    jm1      = j_r - CW'(1);
    is_full  = (count_r == CW'(DEPTH));
    is_empty = (count_r == '0);
    pos_ok   = (PCW'(pos_r) >= PCW'(1)) && (PCW'(pos_r) <= PCW'(count_r));
  end

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    word_nxt       = word_r;
    pos_nxt        = pos_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    j_nxt          = j_r;
    status_nxt     = status_r;
    rd_nxt         = rd_r;
    out_tvalid_nxt = out_tvalid_r;
    out_read_nxt   = out_read_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    mem_we         = 1'b0;
    mem_waddr      = unit_addr;
    mem_wdata      = word_r;
    mem_re         = 1'b0;
    unit_idx       = '0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt   = in_tuser;
          word_nxt   = SW'(in_tdata[VALUE_W-1:0]);
          pos_nxt    = in_tdata[VALUE_W +: POS_W];
          status_nxt = ST_OK;
          rd_nxt     = '0;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESULT;
        case (kind_r) inside
          KIND_PUSH_FRONT: begin
            if (is_full) begin
              status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = head_dec;
              head_nxt  = head_dec;
              count_nxt = count_r + CW'(1);
            end
          end
          KIND_PUSH_REAR: begin
            unit_idx = count_r;
            if (is_full) begin
              status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end
          KIND_POP_FRONT, KIND_PEEK_FRONT: begin
            if (is_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              mem_re    = 1'b1;
              state_nxt = S_RDATA;
            end
          end
          KIND_POP_REAR, KIND_PEEK_REAR: begin
            unit_idx = cnt_m1;
            if (is_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              mem_re    = 1'b1;
              state_nxt = S_RDATA;
            end
          end
          KIND_INSERT: begin
            if (!pos_ok) begin
              status_nxt = ST_BADPOS;
            end else if (is_full) begin
              status_nxt = ST_FULL;
            end else begin
              j_nxt     = count_r;
              state_nxt = (PCW'(count_r) == PCW'(pos_r)) ? S_INSW : S_SHRD;
            end
          end
          default: begin
          end
        endcase
      end
      S_RDATA: begin
        rd_nxt    = rdata_r;
        state_nxt = S_RESULT;
        if (kind_r == KIND_POP_FRONT) begin
          head_nxt  = head_inc;
          count_nxt = cnt_m1;
        end else if (kind_r == KIND_POP_REAR) begin
          count_nxt = cnt_m1;
        end
      end
      S_SHRD: begin
        unit_idx  = jm1;
        mem_re    = 1'b1;
        state_nxt = S_SHWR;
      end
      S_SHWR: begin
        unit_idx  = j_r;
        mem_we    = 1'b1;
        mem_wdata = rdata_r;
        j_nxt     = jm1;
        state_nxt = (PCW'(jm1) == PCW'(pos_r)) ? S_INSW : S_SHRD;
      end
      S_INSW: begin
        unit_idx  = j_r;
        mem_we    = 1'b1;
        count_nxt = count_r + CW'(1);
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_read_nxt   = READ_W'(rd_r);
          out_status_nxt = status_r;
          out_count_nxt  = COUNT_W'(count_r);
          out_empty_nxt  = is_empty;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      head_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      head_r       <= head_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    kind_r       <= kind_nxt;
    word_r       <= word_nxt;
    pos_r        <= pos_nxt;
    j_r          <= j_nxt;
    status_r     <= status_nxt;
    rd_r         <= rd_nxt;
    out_read_r   <= out_read_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[unit_addr];
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_empty_r, out_count_r, out_read_r};
  assign out_tuser  = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("occupancy above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= AW'(DEPTH - 1))
    else $error("head pointer outside buffer");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      ((count_r == $past(count_r) + CW'(1)) || (count_r == $past(count_r) - CW'(1))))
    else $error("occupancy moved by more than one");

  a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_OK)) |-> (out_tdata[READ_W-1:0] == '0))
    else $error("failed operation returned data");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transfer taken while busy");

endmodule

`default_nettype wire
